// ----- rtl/avr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package avr_pkg;

   localparam int CFG_W       = 16;
   localparam int VEC_W       = 24;
   localparam int ENTRY_W     = 18;
   localparam int ENTRY_COUNT = 9;
   localparam int CORDIC_W    = 34;
   localparam int ATAN_W      = 31;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [VEC_W-1:0]   vec_type;

   localparam entry_type ONE_Q16 = 18'sd65536;

   localparam entry_type IDENTITY [ENTRY_COUNT] = '{
      ONE_Q16, 18'sd0, 18'sd0,
      18'sd0, ONE_Q16, 18'sd0,
      18'sd0, 18'sd0, ONE_Q16
   };

   localparam logic [3:0] LAST_ENTRY = 4'(ENTRY_COUNT - 1);

   typedef enum logic [1:0] {
      CSR_AXIS_X = 2'd0,
      CSR_AXIS_Y = 2'd1,
      CSR_AXIS_Z = 2'd2,
      CSR_ANGLE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      TERM_DIAG  = 2'd0,
      TERM_PLUS  = 2'd1,
      TERM_MINUS = 2'd2
   } term_type;

   typedef struct packed {
      logic               load;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle;
   } cfg_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] other;
      term_type   term;
   } entry_info_type;

   function automatic entry_info_type entry_info(input logic [3:0] idx);
      entry_info_type info;
      case (idx)
         4'd0: info = '{row: 2'd0, col: 2'd0, other: 2'd0, term: TERM_DIAG};
         4'd1: info = '{row: 2'd0, col: 2'd1, other: 2'd2, term: TERM_MINUS};
         4'd2: info = '{row: 2'd0, col: 2'd2, other: 2'd1, term: TERM_PLUS};
         4'd3: info = '{row: 2'd1, col: 2'd0, other: 2'd2, term: TERM_PLUS};
         4'd4: info = '{row: 2'd1, col: 2'd1, other: 2'd0, term: TERM_DIAG};
         4'd5: info = '{row: 2'd1, col: 2'd2, other: 2'd0, term: TERM_MINUS};
         4'd6: info = '{row: 2'd2, col: 2'd0, other: 2'd1, term: TERM_MINUS};
         4'd7: info = '{row: 2'd2, col: 2'd1, other: 2'd0, term: TERM_PLUS};
         4'd8: info = '{row: 2'd2, col: 2'd2, other: 2'd0, term: TERM_DIAG};
         default: info = '{row: 2'd0, col: 2'd0, other: 2'd0, term: TERM_DIAG};
      endcase
      return info;
   endfunction

   function automatic logic [ATAN_W-1:0] atan_of(input logic [4:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:  val = 31'd536870912;
         5'd1:  val = 31'd316933406;
         5'd2:  val = 31'd167458907;
         5'd3:  val = 31'd85004756;
         5'd4:  val = 31'd42667331;
         5'd5:  val = 31'd21354465;
         5'd6:  val = 31'd10679838;
         5'd7:  val = 31'd5340245;
         5'd8:  val = 31'd2670163;
         5'd9:  val = 31'd1335087;
         5'd10: val = 31'd667544;
         5'd11: val = 31'd333772;
         5'd12: val = 31'd166886;
         5'd13: val = 31'd83443;
         5'd14: val = 31'd41722;
         5'd15: val = 31'd20861;
         5'd16: val = 31'd10430;
         5'd17: val = 31'd5215;
         5'd18: val = 31'd2608;
         5'd19: val = 31'd1304;
         5'd20: val = 31'd652;
         5'd21: val = 31'd326;
         5'd22: val = 31'd163;
         5'd23: val = 31'd81;
         default: val = 31'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/avr_matrix_gen.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avr_matrix_gen #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  avr_pkg::cfg_type   cfg,
   output logic               busy,
   output avr_pkg::entry_type matrix [avr_pkg::ENTRY_COUNT]
);
   import avr_pkg::*;

   localparam int IterW = $clog2(CORDIC_ITERATIONS);
   localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_ITERATIONS - 1);
   localparam logic signed [CORDIC_W-1:0] GainInit = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] RoundTrig = 34'sd8192;
   localparam logic signed [52:0] RoundEntry = 53'sd134217728;
   localparam logic signed [52:0] EntryMax = 53'sd131071;
   localparam logic signed [52:0] EntryMin = -53'sd131072;
   localparam logic [3:0] EntryCount = 4'(ENTRY_COUNT);

   typedef enum logic [4:0] {
      GEN_IDLE   = 5'b00001,
      GEN_INIT   = 5'b00010,
      GEN_CORDIC = 5'b00100,
      GEN_TRIG   = 5'b01000,
      GEN_MATRIX = 5'b10000
   } gen_state_type;

   gen_state_type state_ff, state_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic [3:0] iss_ff, iss_in;
   logic st1_vld_ff, st1_vld_in;
   logic st2_vld_ff, st2_vld_in;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic flip_ff, flip_in;
   entry_type c_ff, c_in, s_ff, s_in;
   logic signed [ENTRY_W:0] omc_ff, omc_in;

   logic signed [31:0] vv_ff, vv_in;
   logic signed [33:0] vs_ff, vs_in;
   term_type term1_ff;
   logic [3:0] idx1_ff, idx2_ff;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [52:0] add_ff, add_in;

   entry_type mat_ff [ENTRY_COUNT];

   logic signed [15:0] axis [3];
   logic [15:0] angle_adj;
   logic signed [CORDIC_W-1:0] dx, dy, at;
   logic signed [CORDIC_W-1:0] x_rnd, y_rnd;
   entry_type c_raw, s_raw;
   entry_info_type info;
   logic signed [52:0] e_sum, e_q;
   entry_type e_sat;

   always_comb begin
      axis[0] = cfg.axis_x;
      axis[1] = cfg.axis_y;
      axis[2] = cfg.axis_z;

      angle_adj = cfg.angle ^ {cfg.angle[15] ^ cfg.angle[14], 15'd0};
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = $signed({3'b000, atan_of(5'(iter_ff))});
      x_rnd = (x_ff + RoundTrig) >>> 14;
      y_rnd = (y_ff + RoundTrig) >>> 14;
      c_raw = ENTRY_W'(x_rnd);
      s_raw = ENTRY_W'(y_rnd);
      info = entry_info(iss_ff);

      e_sum = 53'(prod_ff) + add_ff + RoundEntry;
      e_q = e_sum >>> 28;
      if (e_q > EntryMax) begin
         e_sat = ENTRY_W'(EntryMax);
      end else if (e_q < EntryMin) begin
         e_sat = ENTRY_W'(EntryMin);
      end else begin
         e_sat = ENTRY_W'(e_q);
      end

      state_in = state_ff;
      iter_in = iter_ff;
      iss_in = iss_ff;
      st1_vld_in = 1'b0;
      st2_vld_in = st1_vld_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      c_in = c_ff;
      s_in = s_ff;
      omc_in = omc_ff;

      case (state_ff)
         GEN_IDLE: begin
            st2_vld_in = 1'b0;
         end
         GEN_INIT: begin
            x_in = GainInit;
            y_in = '0;
            z_in = $signed({{2{angle_adj[15]}}, angle_adj, 16'd0});
            flip_in = cfg.angle[15] ^ cfg.angle[14];
            iter_in = '0;
            state_in = GEN_CORDIC;
         end
         GEN_CORDIC: begin
            if (!z_ff[CORDIC_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LastIter) begin
               state_in = GEN_TRIG;
            end
         end
         GEN_TRIG: begin
            c_in = flip_ff ? -c_raw : c_raw;
            s_in = flip_ff ? -s_raw : s_raw;
            omc_in = $signed({1'b0, ONE_Q16}) - (flip_ff ? -c_raw : c_raw);
            iss_in = '0;
            state_in = GEN_MATRIX;
         end
         GEN_MATRIX: begin
            if (iss_ff < EntryCount) begin
               st1_vld_in = 1'b1;
               iss_in = iss_ff + 1'b1;
            end
            if (st2_vld_ff && idx2_ff == LAST_ENTRY) begin
               state_in = GEN_IDLE;
            end
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase

      if (cfg.load) begin
         state_in = GEN_INIT;
         st1_vld_in = 1'b0;
         st2_vld_in = 1'b0;
      end

      vv_in = axis[info.row] * axis[info.col];
      vs_in = axis[info.other] * s_ff;
      prod_in = omc_ff * vv_ff;
      case (term1_ff)
         TERM_DIAG:  add_in = 53'($signed({c_ff, 28'd0}));
         TERM_PLUS:  add_in = 53'($signed({vs_ff, 14'd0}));
         TERM_MINUS: add_in = -53'($signed({vs_ff, 14'd0}));
         default:    add_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
         iter_ff <= '0;
         iss_ff <= '0;
         st1_vld_ff <= 1'b0;
         st2_vld_ff <= 1'b0;
         for (int k = 0; k < ENTRY_COUNT; k++) begin
            mat_ff[k] <= IDENTITY[k];
         end
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         iss_ff <= iss_in;
         st1_vld_ff <= st1_vld_in;
         st2_vld_ff <= st2_vld_in;
         if (st2_vld_ff && !cfg.load) begin
            mat_ff[idx2_ff] <= e_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      c_ff <= c_in;
      s_ff <= s_in;
      omc_ff <= omc_in;
      vv_ff <= vv_in;
      vs_ff <= vs_in;
      term1_ff <= info.term;
      idx1_ff <= iss_ff;
      prod_ff <= prod_in;
      add_ff <= add_in;
      idx2_ff <= idx1_ff;
   end

   assign busy = (state_ff != GEN_IDLE);
   assign matrix = mat_ff;

endmodule

`default_nettype wire

// ----- rtl/avr_row_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avr_row_lane (
   input  logic               clock,
   input  avr_pkg::entry_type coef_x,
   input  avr_pkg::entry_type coef_y,
   input  avr_pkg::entry_type coef_z,
   input  avr_pkg::vec_type   vec_x,
   input  avr_pkg::vec_type   vec_y,
   input  avr_pkg::vec_type   vec_z,
   output avr_pkg::vec_type   rot
);
   import avr_pkg::*;

   localparam int ProdW = ENTRY_W + VEC_W;
   localparam int SumW = ProdW + 2;
   localparam logic signed [SumW-1:0] RoundOut = SumW'(32768);
   localparam logic signed [SumW-1:0] OutMax = SumW'((1 << (VEC_W - 1)) - 1);
   localparam logic signed [SumW-1:0] OutMin = -OutMax - SumW'(1);

   logic signed [ProdW-1:0] px_ff, py_ff, pz_ff;
   logic signed [SumW-1:0] sum, q;
   vec_type rot_ff, rot_in;

   always_comb begin
      sum = SumW'(px_ff) + SumW'(py_ff) + SumW'(pz_ff) + RoundOut;
      q = sum >>> 16;
      if (q > OutMax) begin
         rot_in = VEC_W'(OutMax);
      end else if (q < OutMin) begin
         rot_in = VEC_W'(OutMin);
      end else begin
         rot_in = VEC_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= coef_x * vec_x;
      py_ff <= coef_y * vec_y;
      pz_ff <= coef_z * vec_z;
      rot_ff <= rot_in;
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

// ----- rtl/axis_angle_vector_rotator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rotates 3-component vectors about a programmed axis by a programmed angle.
// Configuration: csr_wr_en with csr_index (0 axis_x, 1 axis_y, 2 axis_z,
// 3 rotation_angle) and csr_wdata writes one register. Each write rebuilds the
// 3x3 rotation matrix: a setup state, CORDIC_ITERATIONS steps of the
// iterative CORDIC, a state for cos/sin, then a three-stage pipe that forms
// the nine entries. busy stays high until the last entry is written, and no
// vector is taken meanwhile.
// Vectors: a transaction is taken at a clock edge with start high and busy low;
// one vector per cycle is taken back to back. Three row lanes each multiply
// the vector by one matrix row, then round and saturate; the results are
// registered together. rsp_valid is piped beside the data and marks the
// result for exactly one cycle. The receiver cannot stall.
// Reset: registers return to axis (0, 0, 1) and angle zero, the matrix to
// identity, and nothing is in flight.

module axis_angle_vector_rotator #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  avr_pkg::vec_type req_vec_x,
   input  avr_pkg::vec_type req_vec_y,
   input  avr_pkg::vec_type req_vec_z,
   output logic             rsp_valid,
   output avr_pkg::vec_type rsp_rot_x,
   output avr_pkg::vec_type rsp_rot_y,
   output avr_pkg::vec_type rsp_rot_z,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import avr_pkg::*;

   logic signed [CFG_W-1:0] axis_x_ff, axis_y_ff, axis_z_ff, angle_ff;
   cfg_type cfg;
   logic gen_busy;
   entry_type matrix [ENTRY_COUNT];
   vec_type lane_x, lane_y, lane_z;
   logic accept;
   logic v1_ff, v2_ff, rsp_valid_ff;
   vec_type rot_x_ff, rot_y_ff, rot_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= 16'sd0;
         axis_y_ff <= 16'sd0;
         axis_z_ff <= 16'sd16384;
         angle_ff <= 16'sd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AXIS_X: axis_x_ff <= csr_wdata;
            CSR_AXIS_Y: axis_y_ff <= csr_wdata;
            CSR_AXIS_Z: axis_z_ff <= csr_wdata;
            CSR_ANGLE:  angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = '{load: csr_wr_en, axis_x: axis_x_ff, axis_y: axis_y_ff,
                  axis_z: axis_z_ff, angle: angle_ff};

   avr_matrix_gen #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_gen (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .busy(gen_busy),
      .matrix(matrix)
   );

   avr_row_lane u_lane_x (
      .clock(clock),
      .coef_x(matrix[0]), .coef_y(matrix[1]), .coef_z(matrix[2]),
      .vec_x(req_vec_x), .vec_y(req_vec_y), .vec_z(req_vec_z),
      .rot(lane_x)
   );

   avr_row_lane u_lane_y (
      .clock(clock),
      .coef_x(matrix[3]), .coef_y(matrix[4]), .coef_z(matrix[5]),
      .vec_x(req_vec_x), .vec_y(req_vec_y), .vec_z(req_vec_z),
      .rot(lane_y)
   );

   avr_row_lane u_lane_z (
      .clock(clock),
      .coef_x(matrix[6]), .coef_y(matrix[7]), .coef_z(matrix[8]),
      .vec_x(req_vec_x), .vec_y(req_vec_y), .vec_z(req_vec_z),
      .rot(lane_z)
   );

   assign accept = start && !gen_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      rot_x_ff <= lane_x;
      rot_y_ff <= lane_y;
      rot_z_ff <= lane_z;
   end

   assign busy = gen_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rot_x = rot_x_ff;
   assign rsp_rot_y = rot_y_ff;
   assign rsp_rot_z = rot_z_ff;

endmodule

`default_nettype wire
